/* rtl/core/aabb_collision_push_out_unit_assert.svh */
// Assertion macros shared by the box push-out unit; they sample on clk and idle during reset.
`ifndef AABB_COLLISION_PUSH_OUT_UNIT_ASSERT_SVH
`define AABB_COLLISION_PUSH_OUT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACPO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACPO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/acpo_pkg.sv */
// Shared constants and types for the box push-out unit.
`default_nettype none

package acpo_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // A scaled product term is clamped to 2**60, so it needs 61 bits.
    localparam int TERM_W = 61;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef struct packed {
        logic  is_obstacle;
        axis_t axis;
    } item_tag_t;

endpackage

`default_nettype wire

/* rtl/core/acpo_term_mul.sv */
// Magnitude multiplier: product scaled down by the fraction bits and clamped to 2**60.
`default_nettype none

module acpo_term_mul #(
    parameter int WORD_WIDTH = acpo_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = acpo_pkg::FRAC_BITS_DEF
) (
    input  logic [WORD_WIDTH-1:0]      a_mag,
    input  logic [WORD_WIDTH-1:0]      b_mag,
    output logic [acpo_pkg::TERM_W-1:0] term
);
    import acpo_pkg::*;

    localparam int PROD_W = 2 * WORD_WIDTH;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int CMP_W  = (SH_W > TERM_W) ? SH_W : TERM_W;
    localparam logic [CMP_W-1:0] TERM_LIMIT = CMP_W'(1) << (TERM_W - 1);

    logic [PROD_W-1:0] product;
    logic [SH_W-1:0]   shifted;
    logic [CMP_W-1:0]  wide;

    assign product = PROD_W'(a_mag) * PROD_W'(b_mag);
    // Truncation toward zero on the magnitude.
    assign shifted = product[PROD_W-1:FRAC_BITS];
    assign wide    = CMP_W'(shifted);
    assign term    = (wide > TERM_LIMIT) ? TERM_LIMIT[TERM_W-1:0] : wide[TERM_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/acpo_bound_pipe.sv */
// Front pipeline: input register, product register and sum register, giving one axis's bounds.
`default_nettype none

module acpo_bound_pipe #(
    parameter int WORD_WIDTH = acpo_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = acpo_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          is_obstacle,
    input  acpo_pkg::axis_t               axis,
    input  logic signed [WORD_WIDTH-1:0]  row_x,
    input  logic signed [WORD_WIDTH-1:0]  row_y,
    input  logic signed [WORD_WIDTH-1:0]  row_z,
    input  logic signed [WORD_WIDTH-1:0]  row_offset,
    input  logic signed [WORD_WIDTH-1:0]  center_x,
    input  logic signed [WORD_WIDTH-1:0]  center_y,
    input  logic signed [WORD_WIDTH-1:0]  center_z,
    input  logic        [WORD_WIDTH-2:0]  half_x,
    input  logic        [WORD_WIDTH-2:0]  half_y,
    input  logic        [WORD_WIDTH-2:0]  half_z,
    output logic                          bnd_valid,
    output acpo_pkg::item_tag_t           bnd_tag,
    output logic signed [WORD_WIDTH-1:0]  bnd_low,
    output logic signed [WORD_WIDTH-1:0]  bnd_high,
    input  logic                          bnd_take
);
    import acpo_pkg::*;

    localparam int CEN_W = TERM_W + 3;
    localparam int EXT_W = TERM_W + 2;
    localparam int BND_W = CEN_W + 1;
    localparam logic signed [BND_W-1:0] SAT_MAX =
        {{(BND_W - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
    localparam logic signed [BND_W-1:0] SAT_MIN = ~SAT_MAX;

    // Input register.
    logic                         s0_valid_reg;
    item_tag_t                    s0_tag_reg;
    logic signed [WORD_WIDTH-1:0] row_reg    [3];
    logic signed [WORD_WIDTH-1:0] center_reg [3];
    logic        [WORD_WIDTH-2:0] half_reg   [3];
    logic signed [WORD_WIDTH-1:0] offset_reg;

    // Product register.
    logic                         s1_valid_reg;
    item_tag_t                    s1_tag_reg;
    logic signed [TERM_W:0]       ctr_term_reg [3];
    logic        [TERM_W-1:0]     ext_term_reg [3];
    logic signed [WORD_WIDTH-1:0] s1_offset_reg;

    // Sum register.
    logic                         s2_valid_reg;
    item_tag_t                    s2_tag_reg;
    logic signed [CEN_W-1:0]      cen_reg;
    logic        [EXT_W-1:0]      ext_reg;

    logic                         s0_free;
    logic                         s1_free;
    logic                         s2_free;
    logic                         axis_ok;

    logic        [WORD_WIDTH-1:0] row_mag    [3];
    logic        [WORD_WIDTH-1:0] center_mag [3];
    logic        [WORD_WIDTH-1:0] half_ext   [3];
    logic                         ctr_neg    [3];
    logic        [TERM_W-1:0]     ctr_mag    [3];
    logic        [TERM_W-1:0]     ext_mag    [3];
    logic signed [TERM_W:0]       ctr_term_next [3];

    logic signed [CEN_W-1:0]      cen_next;
    logic        [EXT_W-1:0]      ext_next;
    logic signed [BND_W-1:0]      low_wide;
    logic signed [BND_W-1:0]      high_wide;

    // Ready chain: a stage can load when it is empty or its item moves on.
    assign s2_free  = !s2_valid_reg || bnd_take;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign in_stall = !s0_free;
    // Items on the unused axis code are taken and dropped.
    assign axis_ok  = (axis == AXIS_X) || (axis == AXIS_Y) || (axis == AXIS_Z);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row_mag[i]    = row_reg[i][WORD_WIDTH-1] ? WORD_WIDTH'(-row_reg[i])
                                                     : WORD_WIDTH'(row_reg[i]);
            center_mag[i] = center_reg[i][WORD_WIDTH-1] ? WORD_WIDTH'(-center_reg[i])
                                                        : WORD_WIDTH'(center_reg[i]);
            half_ext[i]   = {1'b0, half_reg[i]};
            ctr_neg[i]    = row_reg[i][WORD_WIDTH-1] ^ center_reg[i][WORD_WIDTH-1];
            ctr_term_next[i] = ctr_neg[i] ? -$signed({1'b0, ctr_mag[i]})
                                          : $signed({1'b0, ctr_mag[i]});
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_mul
        acpo_term_mul #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_ctr_mul (
            .a_mag (row_mag[g]),
            .b_mag (center_mag[g]),
            .term  (ctr_mag[g])
        );

        acpo_term_mul #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_ext_mul (
            .a_mag (row_mag[g]),
            .b_mag (half_ext[g]),
            .term  (ext_mag[g])
        );
    end

    assign cen_next = CEN_W'(s1_offset_reg) + CEN_W'(ctr_term_reg[0])
                    + CEN_W'(ctr_term_reg[1]) + CEN_W'(ctr_term_reg[2]);
    assign ext_next = EXT_W'(ext_term_reg[0]) + EXT_W'(ext_term_reg[1])
                    + EXT_W'(ext_term_reg[2]);

    assign low_wide  = BND_W'(cen_reg) - $signed(BND_W'(ext_reg));
    assign high_wide = BND_W'(cen_reg) + $signed(BND_W'(ext_reg));

    always_comb
    begin
        if (low_wide > SAT_MAX)
        begin
            bnd_low = SAT_MAX[WORD_WIDTH-1:0];
        end
        else if (low_wide < SAT_MIN)
        begin
            bnd_low = SAT_MIN[WORD_WIDTH-1:0];
        end
        else
        begin
            bnd_low = low_wide[WORD_WIDTH-1:0];
        end

        if (high_wide > SAT_MAX)
        begin
            bnd_high = SAT_MAX[WORD_WIDTH-1:0];
        end
        else if (high_wide < SAT_MIN)
        begin
            bnd_high = SAT_MIN[WORD_WIDTH-1:0];
        end
        else
        begin
            bnd_high = high_wide[WORD_WIDTH-1:0];
        end
    end

    assign bnd_valid = s2_valid_reg;
    assign bnd_tag   = s2_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= in_valid && axis_ok;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_free && in_valid)
        begin
            s0_tag_reg    <= '{is_obstacle: is_obstacle, axis: axis};
            row_reg[0]    <= row_x;
            row_reg[1]    <= row_y;
            row_reg[2]    <= row_z;
            center_reg[0] <= center_x;
            center_reg[1] <= center_y;
            center_reg[2] <= center_z;
            half_reg[0]   <= half_x;
            half_reg[1]   <= half_y;
            half_reg[2]   <= half_z;
            offset_reg    <= row_offset;
        end
        if (s1_free && s0_valid_reg)
        begin
            s1_tag_reg    <= s0_tag_reg;
            s1_offset_reg <= offset_reg;
            for (int i = 0; i < 3; i++)
            begin
                ctr_term_reg[i] <= ctr_term_next[i];
                ext_term_reg[i] <= ext_mag[i];
            end
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_tag_reg <= s1_tag_reg;
            cen_reg    <= cen_next;
            ext_reg    <= ext_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/acpo_resolve.sv */
// Back pipeline: bound snapshot, per-axis overlap, then axis choice and the output register.
`default_nettype none

module acpo_resolve #(
    parameter int WORD_WIDTH = acpo_pkg::WORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          snap_offer,
    output logic                          snap_free,
    input  logic signed [WORD_WIDTH-1:0]  mover_low     [3],
    input  logic signed [WORD_WIDTH-1:0]  mover_high    [3],
    input  logic signed [WORD_WIDTH-1:0]  obstacle_low  [3],
    input  logic signed [WORD_WIDTH-1:0]  obstacle_high [3],
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          collided,
    output logic signed [WORD_WIDTH-1:0]  push_x,
    output logic signed [WORD_WIDTH-1:0]  push_y,
    output logic signed [WORD_WIDTH-1:0]  push_z
);
    import acpo_pkg::*;

    localparam logic signed [WORD_WIDTH:0] SAT_MAX = {2'b00, {(WORD_WIDTH - 1){1'b1}}};

    logic                         snap_valid_reg;
    logic signed [WORD_WIDTH-1:0] m_lo_reg [3];
    logic signed [WORD_WIDTH-1:0] m_hi_reg [3];
    logic signed [WORD_WIDTH-1:0] o_lo_reg [3];
    logic signed [WORD_WIDTH-1:0] o_hi_reg [3];

    logic                         ovl_valid_reg;
    logic signed [WORD_WIDTH:0]   ov_reg  [3];
    logic                         neg_reg [3];

    logic                         out_valid_reg;
    logic                         collided_reg;
    logic signed [WORD_WIDTH-1:0] push_reg [3];

    logic                         ovl_free;
    logic                         out_free;

    logic signed [WORD_WIDTH-1:0] hi_min  [3];
    logic signed [WORD_WIDTH-1:0] lo_max  [3];
    logic signed [WORD_WIDTH:0]   ov_next [3];
    logic signed [WORD_WIDTH:0]   m_sum   [3];
    logic signed [WORD_WIDTH:0]   o_sum   [3];
    logic                         neg_next [3];

    logic                         positive [3];
    logic                         pick     [3];
    logic                         hit;
    logic        [WORD_WIDTH-1:0] mag      [3];
    logic signed [WORD_WIDTH-1:0] push_next [3];

    assign out_free  = !out_valid_reg || !out_stall;
    assign ovl_free  = !ovl_valid_reg || out_free;
    assign snap_free = !snap_valid_reg || ovl_free;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hi_min[i]   = (m_hi_reg[i] < o_hi_reg[i]) ? m_hi_reg[i] : o_hi_reg[i];
            lo_max[i]   = (m_lo_reg[i] > o_lo_reg[i]) ? m_lo_reg[i] : o_lo_reg[i];
            ov_next[i]  = (WORD_WIDTH + 1)'(hi_min[i]) - (WORD_WIDTH + 1)'(lo_max[i]);
            m_sum[i]    = (WORD_WIDTH + 1)'(m_lo_reg[i]) + (WORD_WIDTH + 1)'(m_hi_reg[i]);
            o_sum[i]    = (WORD_WIDTH + 1)'(o_lo_reg[i]) + (WORD_WIDTH + 1)'(o_hi_reg[i]);
            neg_next[i] = m_sum[i] < o_sum[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            positive[i] = !ov_reg[i][WORD_WIDTH] && (ov_reg[i] != '0);
            mag[i]      = (ov_reg[i] > SAT_MAX) ? SAT_MAX[WORD_WIDTH-1:0]
                                                : ov_reg[i][WORD_WIDTH-1:0];
        end
        hit = positive[0] && positive[1] && positive[2];
        // Least overlap wins; a tie goes to the later axis, so z beats y and x, and y beats x.
        pick[0] = (ov_reg[0] < ov_reg[1]) && (ov_reg[0] < ov_reg[2]);
        pick[1] = !pick[0] && (ov_reg[1] < ov_reg[2]);
        pick[2] = !pick[0] && !pick[1];
        for (int i = 0; i < 3; i++)
        begin
            if (hit && pick[i])
            begin
                push_next[i] = neg_reg[i] ? -$signed(mag[i]) : $signed(mag[i]);
            end
            else
            begin
                push_next[i] = '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign collided  = collided_reg;
    assign push_x    = push_reg[0];
    assign push_y    = push_reg[1];
    assign push_z    = push_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            ovl_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (snap_free)
            begin
                snap_valid_reg <= snap_offer;
            end
            if (ovl_free)
            begin
                ovl_valid_reg <= snap_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= ovl_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_free && snap_offer)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_lo_reg[i] <= mover_low[i];
                m_hi_reg[i] <= mover_high[i];
                o_lo_reg[i] <= obstacle_low[i];
                o_hi_reg[i] <= obstacle_high[i];
            end
        end
        if (ovl_free && snap_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ov_reg[i]  <= ov_next[i];
                neg_reg[i] <= neg_next[i];
            end
        end
        if (out_free && ovl_valid_reg)
        begin
            collided_reg <= hit;
            for (int i = 0; i < 3; i++)
            begin
                push_reg[i] <= push_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aabb_collision_push_out_unit.sv */
// Box collision push-out unit: one world-matrix row per transfer, bounds kept per box and axis.
// Path of a closing obstacle z-row: input, product, sum, snapshot, overlap, output registers.
// Throughput: one transfer per cycle unless stalled; the six row multipliers work in parallel.
// Stored bounds reset to zero asynchronously on rst_n; pipeline valid flags clear with them.
`default_nettype none
`include "aabb_collision_push_out_unit_assert.svh"

module aabb_collision_push_out_unit #(
    parameter int WORD_WIDTH = acpo_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = acpo_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          is_obstacle,
    input  acpo_pkg::axis_t               axis,
    input  logic signed [WORD_WIDTH-1:0]  row_x,
    input  logic signed [WORD_WIDTH-1:0]  row_y,
    input  logic signed [WORD_WIDTH-1:0]  row_z,
    input  logic signed [WORD_WIDTH-1:0]  row_offset,
    input  logic signed [WORD_WIDTH-1:0]  center_x,
    input  logic signed [WORD_WIDTH-1:0]  center_y,
    input  logic signed [WORD_WIDTH-1:0]  center_z,
    input  logic        [WORD_WIDTH-2:0]  half_x,
    input  logic        [WORD_WIDTH-2:0]  half_y,
    input  logic        [WORD_WIDTH-2:0]  half_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          collided,
    output logic signed [WORD_WIDTH-1:0]  push_x,
    output logic signed [WORD_WIDTH-1:0]  push_y,
    output logic signed [WORD_WIDTH-1:0]  push_z
);
    import acpo_pkg::*;

    // Bounds leaving the front pipeline, one box axis per transfer.
    logic                         bnd_valid;
    item_tag_t                    bnd_tag;
    logic signed [WORD_WIDTH-1:0] bnd_low;
    logic signed [WORD_WIDTH-1:0] bnd_high;
    logic                         bnd_take;
    logic                         bnd_query;
    logic                         store_write;
    logic                         snap_free;

    // Bounds of the last rows seen for each box, indexed by world axis.
    logic signed [WORD_WIDTH-1:0] mover_low_reg     [3];
    logic signed [WORD_WIDTH-1:0] mover_high_reg    [3];
    logic signed [WORD_WIDTH-1:0] obstacle_low_reg  [3];
    logic signed [WORD_WIDTH-1:0] obstacle_high_reg [3];

    // Snapshot seen by the query, with its own fresh obstacle z bounds forwarded.
    logic signed [WORD_WIDTH-1:0] snap_ob_low  [3];
    logic signed [WORD_WIDTH-1:0] snap_ob_high [3];

    acpo_bound_pipe #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_bound_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .is_obstacle (is_obstacle),
        .axis        (axis),
        .row_x       (row_x),
        .row_y       (row_y),
        .row_z       (row_z),
        .row_offset  (row_offset),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .half_x      (half_x),
        .half_y      (half_y),
        .half_z      (half_z),
        .bnd_valid   (bnd_valid),
        .bnd_tag     (bnd_tag),
        .bnd_low     (bnd_low),
        .bnd_high    (bnd_high),
        .bnd_take    (bnd_take)
    );

    // The obstacle's z row closes a query and needs room in the back pipeline.
    // Every other row only updates the bound store and leaves at once. The
    // snapshot is captured at the same edge as the store write, so later rows
    // cannot disturb a query that is waiting further down.
    assign bnd_query   = bnd_tag.is_obstacle && (bnd_tag.axis == AXIS_Z);
    assign bnd_take    = !bnd_query || snap_free;
    assign store_write = bnd_valid && bnd_take;

    always_comb
    begin
        snap_ob_low[0]  = obstacle_low_reg[0];
        snap_ob_low[1]  = obstacle_low_reg[1];
        snap_ob_low[2]  = bnd_low;
        snap_ob_high[0] = obstacle_high_reg[0];
        snap_ob_high[1] = obstacle_high_reg[1];
        snap_ob_high[2] = bnd_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mover_low_reg[i]     <= '0;
                mover_high_reg[i]    <= '0;
                obstacle_low_reg[i]  <= '0;
                obstacle_high_reg[i] <= '0;
            end
        end
        else if (store_write)
        begin
            if (bnd_tag.is_obstacle)
            begin
                obstacle_low_reg[bnd_tag.axis]  <= bnd_low;
                obstacle_high_reg[bnd_tag.axis] <= bnd_high;
            end
            else
            begin
                mover_low_reg[bnd_tag.axis]  <= bnd_low;
                mover_high_reg[bnd_tag.axis] <= bnd_high;
            end
        end
    end

    acpo_resolve #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_resolve (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_offer    (bnd_valid && bnd_query),
        .snap_free     (snap_free),
        .mover_low     (mover_low_reg),
        .mover_high    (mover_high_reg),
        .obstacle_low  (snap_ob_low),
        .obstacle_high (snap_ob_high),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .collided      (collided),
        .push_x        (push_x),
        .push_y        (push_y),
        .push_z        (push_z)
    );

    // A collision pushes along exactly one axis; a miss pushes along none.
    `ACPO_ASSERT_NOW(a_hit_one_axis, out_valid && collided,
        $onehot({push_x != '0, push_y != '0, push_z != '0}), "hit must push on one axis")
    `ACPO_ASSERT_NOW(a_miss_no_push, out_valid && !collided,
        (push_x == '0) && (push_y == '0) && (push_z == '0), "miss must give zero push")
    // Extents are never negative, so every stored low bound sits at or below its high bound.
    `ACPO_ASSERT_NOW(a_bounds_ordered, 1'b1,
        (mover_low_reg[0] <= mover_high_reg[0]) && (mover_low_reg[1] <= mover_high_reg[1])
        && (mover_low_reg[2] <= mover_high_reg[2])
        && (obstacle_low_reg[0] <= obstacle_high_reg[0])
        && (obstacle_low_reg[1] <= obstacle_high_reg[1])
        && (obstacle_low_reg[2] <= obstacle_high_reg[2]), "stored bounds out of order")
    // A closing row that leaves the front pipeline lands in the store.
    `ACPO_ASSERT_NEXT(a_query_stored, store_write && bnd_query,
        obstacle_high_reg[2] == $past(bnd_high), "query bounds not stored")

endmodule

`default_nettype wire
